### hdl/ttb_pkg.sv
// Shared constants, types and controller encodings for the triangle tile binner.
// Used by every other file in the block; depends on nothing.
package ttb_pkg;

  localparam int TILE_SHIFT  = 6;
  localparam int MAX_TILES_X = 8;
  localparam int MAX_TILES_Y = 8;

  localparam int CRD_W   = 16;                // vertex coordinate
  localparam int DLT_W   = CRD_W + 1;         // edge delta
  localparam int ORI_W   = 2 * DLT_W + 1;     // orientation difference
  localparam int PRD_W   = DLT_W + CRD_W;     // delta times coordinate
  localparam int OFF_W   = PRD_W + 1;         // edge offset
  localparam int EDGE_W  = OFF_W + 3;         // edge value at a tile corner
  localparam int TIX_W   = CRD_W + 1;         // unclamped tile index
  localparam int IDX_W   = 3;                 // tile column / row
  localparam int FACE_W  = 16;
  localparam int CNT_W   = 4;
  localparam int SCR_W   = 10;
  localparam int FAR_W   = SCR_W + 2;
  localparam int STEP_SH = TILE_SHIFT + 4;    // pixels of a tile, with fraction bits
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = SCR_W;

  localparam logic signed [TIX_W-1:0] ROUND_UP = TIX_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILES_ACROSS  = 2'd0,
    CFG_TILES_DOWN    = 2'd1,
    CFG_SCREEN_WIDTH  = 2'd2,
    CFG_SCREEN_HEIGHT = 2'd3
  } ttb_cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_CULL,
    ST_INIT,
    ST_WALK,
    ST_FLUSH
  } ttb_state_e;

  typedef struct packed {
    logic cap;
    logic diff;
    logic mult;
    logic cull;
    logic init;
    logic step;
    logic flush;
  } ttb_cmd_t;

  typedef struct packed {
    logic culled;
    logic empty;
    logic at_end;
    logic touched;
    logic pend;
    logic out_free;
  } ttb_stat_t;

endpackage

### hdl/ttb_intf.sv
// Channel interfaces of the triangle tile binner: triangle in, tile out, register write.
// Depends on ttb_pkg for field widths.
interface ttb_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ttb_pkg::CRD_W-1:0]    vert1_x;
  logic signed [ttb_pkg::CRD_W-1:0]    vert1_y;
  logic signed [ttb_pkg::CRD_W-1:0]    vert2_x;
  logic signed [ttb_pkg::CRD_W-1:0]    vert2_y;
  logic signed [ttb_pkg::CRD_W-1:0]    vert3_x;
  logic signed [ttb_pkg::CRD_W-1:0]    vert3_y;
  logic        [ttb_pkg::FACE_W-1:0]   face_number;
  modport source (output valid, vert1_x, vert1_y, vert2_x, vert2_y, vert3_x, vert3_y,
                  face_number, input ready);
  modport sink (input valid, vert1_x, vert1_y, vert2_x, vert2_y, vert3_x, vert3_y,
                face_number, output ready);
endinterface

interface ttb_out_if;
  logic                              valid;
  logic                              ready;
  logic [ttb_pkg::IDX_W-1:0]         tile_col;
  logic [ttb_pkg::IDX_W-1:0]         tile_row;
  logic [ttb_pkg::FACE_W-1:0]        face_out;
  logic                              full_cover;
  logic                              last_tile;
  modport source (output valid, tile_col, tile_row, face_out, full_cover, last_tile,
                  input ready);
  modport sink (input valid, tile_col, tile_row, face_out, full_cover, last_tile,
                output ready);
endinterface

interface ttb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ttb_pkg::CFG_IDX_W-1:0]      index;
  logic [ttb_pkg::CFG_DAT_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/ttb_ctrl.sv
// Sequencer of the tile binner: setup steps, tile walk and final flush.
// Depends on ttb_pkg; drives the datapath through ttb_cmd_t only.
module ttb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ttb_pkg::ttb_stat_t stat_i,
  output ttb_pkg::ttb_cmd_t  cmd_o
);

  ttb_pkg::ttb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    logic step_ok;
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    step_ok    = !stat_i.touched || !stat_i.pend || stat_i.out_free;
    unique case (state_q)
      ttb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ttb_pkg::ST_DIFF;
        end
      end
      ttb_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ttb_pkg::ST_MUL;
      end
      ttb_pkg::ST_MUL: begin
        cmd_o.mult = 1'b1;
        state_d    = ttb_pkg::ST_CULL;
      end
      ttb_pkg::ST_CULL: begin
        cmd_o.cull = 1'b1;
        state_d    = ttb_pkg::ST_INIT;
      end
      ttb_pkg::ST_INIT: begin
        if (stat_i.culled || stat_i.empty) begin
          state_d = ttb_pkg::ST_IDLE;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = ttb_pkg::ST_WALK;
        end
      end
      ttb_pkg::ST_WALK: begin
        // hold the walk while a touched tile has nowhere to go
        cmd_o.step = step_ok;
        if (step_ok && stat_i.at_end) begin
          state_d = ttb_pkg::ST_FLUSH;
        end
      end
      ttb_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (!stat_i.pend || stat_i.out_free) begin
          state_d = ttb_pkg::ST_IDLE;
        end
      end
      default: state_d = ttb_pkg::ST_IDLE;
    endcase
  end

endmodule

### hdl/ttb_dpath.sv
// Datapath of the tile binner: edge setup, bounds, incremental corner tests and result buffering.
// Depends on ttb_pkg; sequenced by ttb_ctrl through ttb_cmd_t.
module ttb_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ttb_pkg::ttb_cmd_t                  cmd_i,
  output ttb_pkg::ttb_stat_t                 stat_o,
  input  logic signed [ttb_pkg::CRD_W-1:0]   vert1_x_i,
  input  logic signed [ttb_pkg::CRD_W-1:0]   vert1_y_i,
  input  logic signed [ttb_pkg::CRD_W-1:0]   vert2_x_i,
  input  logic signed [ttb_pkg::CRD_W-1:0]   vert2_y_i,
  input  logic signed [ttb_pkg::CRD_W-1:0]   vert3_x_i,
  input  logic signed [ttb_pkg::CRD_W-1:0]   vert3_y_i,
  input  logic        [ttb_pkg::FACE_W-1:0]  face_i,
  input  logic                               cfg_we_i,
  input  logic        [ttb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [ttb_pkg::CFG_DAT_W-1:0] cfg_dat_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic        [ttb_pkg::IDX_W-1:0]   tile_col_o,
  output logic        [ttb_pkg::IDX_W-1:0]   tile_row_o,
  output logic        [ttb_pkg::FACE_W-1:0]  face_out_o,
  output logic                               full_cover_o,
  output logic                               last_tile_o
);

  localparam int EW = ttb_pkg::EDGE_W;
  localparam int XW = ttb_pkg::DLT_W + ttb_pkg::IDX_W + 1;

  // configuration
  logic [ttb_pkg::CNT_W-1:0] across_q, down_q;
  logic [ttb_pkg::SCR_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= ttb_pkg::CNT_W'(8);
      down_q   <= ttb_pkg::CNT_W'(8);
      width_q  <= ttb_pkg::SCR_W'(512);
      height_q <= ttb_pkg::SCR_W'(512);
    end else if (cfg_we_i) begin
      unique case (ttb_pkg::ttb_cfg_reg_e'(cfg_idx_i))
        ttb_pkg::CFG_TILES_ACROSS:  across_q <= cfg_dat_i[ttb_pkg::CNT_W-1:0];
        ttb_pkg::CFG_TILES_DOWN:    down_q   <= cfg_dat_i[ttb_pkg::CNT_W-1:0];
        ttb_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_dat_i;
        ttb_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_dat_i;
        default: ;
      endcase
    end
  end

  // captured triangle
  logic signed [ttb_pkg::CRD_W-1:0] px_q [3];
  logic signed [ttb_pkg::CRD_W-1:0] py_q [3];
  logic        [ttb_pkg::FACE_W-1:0] face_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      px_q[0] <= vert1_x_i;  py_q[0] <= vert1_y_i;
      px_q[1] <= vert2_x_i;  py_q[1] <= vert2_y_i;
      px_q[2] <= vert3_x_i;  py_q[2] <= vert3_y_i;
      face_q  <= face_i;
    end
  end

  // deltas and raw tile bounds
  logic signed [ttb_pkg::DLT_W-1:0] dx_q [3];
  logic signed [ttb_pkg::DLT_W-1:0] dy_q [3];
  logic signed [ttb_pkg::TIX_W-1:0] cmin_r_q, cmax_r_q, rmin_r_q, rmax_r_q;
  logic signed [ttb_pkg::TIX_W-1:0] xs [3];
  logic signed [ttb_pkg::TIX_W-1:0] ys [3];
  logic signed [ttb_pkg::TIX_W-1:0] xlo, xhi, ylo, yhi;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = ttb_pkg::TIX_W'(px_q[i]);
      ys[i] = ttb_pkg::TIX_W'(py_q[i]);
    end
    xlo = (xs[0] < xs[1]) ? xs[0] : xs[1];
    xlo = (xlo < xs[2]) ? xlo : xs[2];
    xhi = (xs[0] > xs[1]) ? xs[0] : xs[1];
    xhi = (xhi > xs[2]) ? xhi : xs[2];
    ylo = (ys[0] < ys[1]) ? ys[0] : ys[1];
    ylo = (ylo < ys[2]) ? ylo : ys[2];
    yhi = (ys[0] > ys[1]) ? ys[0] : ys[1];
    yhi = (yhi > ys[2]) ? yhi : ys[2];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      for (int i = 0; i < 3; i++) begin
        dx_q[i] <= ttb_pkg::DLT_W'(px_q[(i + 1) % 3]) - ttb_pkg::DLT_W'(px_q[i]);
        dy_q[i] <= ttb_pkg::DLT_W'(py_q[(i + 1) % 3]) - ttb_pkg::DLT_W'(py_q[i]);
      end
      // round up to whole pixels, then down to tiles
      cmin_r_q <= (xlo + ttb_pkg::ROUND_UP) >>> ttb_pkg::STEP_SH;
      cmax_r_q <= (xhi + ttb_pkg::ROUND_UP) >>> ttb_pkg::STEP_SH;
      rmin_r_q <= (ylo + ttb_pkg::ROUND_UP) >>> ttb_pkg::STEP_SH;
      rmax_r_q <= (yhi + ttb_pkg::ROUND_UP) >>> ttb_pkg::STEP_SH;
    end
  end

  // products
  logic signed [2*ttb_pkg::DLT_W-1:0] ori_a_q, ori_b_q, ori_a, ori_b;
  logic signed [ttb_pkg::PRD_W-1:0]   pa_q [3];
  logic signed [ttb_pkg::PRD_W-1:0]   pb_q [3];
  logic signed [ttb_pkg::PRD_W-1:0]   pa [3];
  logic signed [ttb_pkg::PRD_W-1:0]   pb [3];

  always_comb begin
    ori_a = dx_q[2] * dy_q[0];
    ori_b = dx_q[0] * dy_q[2];
    for (int i = 0; i < 3; i++) begin
      pa[i] = dy_q[i] * px_q[i];
      pb[i] = dx_q[i] * py_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      ori_a_q <= ori_a;
      ori_b_q <= ori_b;
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= pa[i];
        pb_q[i] <= pb[i];
      end
    end
  end

  // orientation, offsets, corner spans, clamped bounds
  logic signed [ttb_pkg::ORI_W-1:0]  orient;
  logic signed [ttb_pkg::OFF_W-1:0]  off_q [3];
  logic signed [EW-1:0]              spx_q [3];
  logic signed [EW-1:0]              spy_q [3];
  logic                              culled_q, empty_q;
  logic        [ttb_pkg::IDX_W-1:0]  cmin_q, cmax_q, rmin_q, rmax_q;
  logic signed [ttb_pkg::TIX_W-1:0]  nx, ny, cmin_c, cmax_c, rmin_c, rmax_c;

  always_comb begin
    orient = ttb_pkg::ORI_W'(ori_a_q) - ttb_pkg::ORI_W'(ori_b_q);
    nx = (across_q > ttb_pkg::CNT_W'(ttb_pkg::MAX_TILES_X)) ?
         ttb_pkg::TIX_W'(ttb_pkg::MAX_TILES_X) : ttb_pkg::TIX_W'(across_q);
    ny = (down_q > ttb_pkg::CNT_W'(ttb_pkg::MAX_TILES_Y)) ?
         ttb_pkg::TIX_W'(ttb_pkg::MAX_TILES_Y) : ttb_pkg::TIX_W'(down_q);
    cmin_c = (cmin_r_q < 0) ? '0 : cmin_r_q;
    rmin_c = (rmin_r_q < 0) ? '0 : rmin_r_q;
    cmax_c = (cmax_r_q >= nx) ? nx - ttb_pkg::TIX_W'(1) : cmax_r_q;
    rmax_c = (rmax_r_q >= ny) ? ny - ttb_pkg::TIX_W'(1) : rmax_r_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cull) begin
      for (int i = 0; i < 3; i++) begin
        // top-left rule: bias edges going down, or flat and to the right
        off_q[i] <= ttb_pkg::OFF_W'(pb_q[i]) - ttb_pkg::OFF_W'(pa_q[i]) +
                    ttb_pkg::OFF_W'((dy_q[i] > 0) || (dy_q[i] == 0 && dx_q[i] > 0));
        spx_q[i] <= (EW'(dy_q[i]) <<< ttb_pkg::STEP_SH) - (EW'(dy_q[i]) <<< 4);
        spy_q[i] <= (EW'(dx_q[i]) <<< ttb_pkg::STEP_SH) - (EW'(dx_q[i]) <<< 4);
      end
      cmin_q <= cmin_c[ttb_pkg::IDX_W-1:0];
      cmax_q <= cmax_c[ttb_pkg::IDX_W-1:0];
      rmin_q <= rmin_c[ttb_pkg::IDX_W-1:0];
      rmax_q <= rmax_c[ttb_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      culled_q <= 1'b0;
      empty_q  <= 1'b0;
    end else if (cmd_i.cull) begin
      culled_q <= orient > 0;
      empty_q  <= (nx == 0) || (ny == 0) || (cmax_c < 0) || (rmax_c < 0) ||
                  (cmin_c > cmax_c) || (rmin_c > rmax_c);
    end
  end

  // tile walk
  logic signed [EW-1:0] e_q [3];
  logic signed [EW-1:0] erow_q [3];
  logic signed [EW-1:0] dys [3];
  logic signed [EW-1:0] dxs [3];
  logic signed [XW-1:0] mcx [3];
  logic signed [XW-1:0] mry [3];
  logic        [ttb_pkg::IDX_W-1:0] col_q, row_q;
  logic [2:0] any_in, all_in;
  logic       touched, full_size, at_end;
  logic signed [EW-1:0] c00, c10, c01, c11;
  logic [ttb_pkg::FAR_W-1:0] far_x, far_y;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dys[i] = EW'(dy_q[i]) <<< ttb_pkg::STEP_SH;
      dxs[i] = EW'(dx_q[i]) <<< ttb_pkg::STEP_SH;
      mcx[i] = dy_q[i] * $signed({1'b0, cmin_q});
      mry[i] = dx_q[i] * $signed({1'b0, rmin_q});
      c00 = e_q[i];
      c10 = e_q[i] + spx_q[i];
      c01 = e_q[i] - spy_q[i];
      c11 = c10 - spy_q[i];
      any_in[i] = (c00 > 0) || (c10 > 0) || (c01 > 0) || (c11 > 0);
      all_in[i] = (c00 > 0) && (c10 > 0) && (c01 > 0) && (c11 > 0);
    end
    touched   = &any_in;
    far_x     = (ttb_pkg::FAR_W'(col_q) + ttb_pkg::FAR_W'(1)) << ttb_pkg::TILE_SHIFT;
    far_y     = (ttb_pkg::FAR_W'(row_q) + ttb_pkg::FAR_W'(1)) << ttb_pkg::TILE_SHIFT;
    full_size = (ttb_pkg::FAR_W'(width_q) >= far_x) && (ttb_pkg::FAR_W'(height_q) >= far_y);
    at_end    = (col_q == cmax_q) && (row_q == rmax_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      for (int i = 0; i < 3; i++) begin
        e_q[i]    <= EW'(off_q[i]) + (EW'(mcx[i]) <<< ttb_pkg::STEP_SH) -
                     (EW'(mry[i]) <<< ttb_pkg::STEP_SH);
        erow_q[i] <= EW'(off_q[i]) + (EW'(mcx[i]) <<< ttb_pkg::STEP_SH) -
                     (EW'(mry[i]) <<< ttb_pkg::STEP_SH);
      end
      col_q <= cmin_q;
      row_q <= rmin_q;
    end else if (cmd_i.step) begin
      if (col_q == cmax_q) begin
        for (int i = 0; i < 3; i++) begin
          erow_q[i] <= erow_q[i] - dxs[i];
          e_q[i]    <= erow_q[i] - dxs[i];
        end
        col_q <= cmin_q;
        row_q <= row_q + ttb_pkg::IDX_W'(1);
      end else begin
        for (int i = 0; i < 3; i++) begin
          e_q[i] <= e_q[i] + dys[i];
        end
        col_q <= col_q + ttb_pkg::IDX_W'(1);
      end
    end
  end

  // one tile waits in the pending stage until the next touched tile or the end decides last
  logic                       pend_q, out_valid_q, out_last_q, out_full_q, pend_full_q;
  logic [ttb_pkg::IDX_W-1:0]  pend_col_q, pend_row_q, out_col_q, out_row_q;
  logic [ttb_pkg::FACE_W-1:0] out_face_q;
  logic                       out_free, ld_walk, ld_flush, new_pend;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    new_pend = cmd_i.step && touched;
    ld_walk  = new_pend && pend_q;
    ld_flush = cmd_i.flush && pend_q && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (new_pend) begin
        pend_q <= 1'b1;
      end else if (ld_flush) begin
        pend_q <= 1'b0;
      end
      if (ld_walk || ld_flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_pend) begin
      pend_col_q  <= col_q;
      pend_row_q  <= row_q;
      pend_full_q <= (&all_in) && full_size;
    end
    if (ld_walk || ld_flush) begin
      out_col_q  <= pend_col_q;
      out_row_q  <= pend_row_q;
      out_full_q <= pend_full_q;
      out_face_q <= face_q;
      out_last_q <= ld_flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tile_col_o   = out_col_q;
  assign tile_row_o   = out_row_q;
  assign face_out_o   = out_face_q;
  assign full_cover_o = out_full_q;
  assign last_tile_o  = out_last_q;

  assign stat_o.culled   = culled_q;
  assign stat_o.empty    = empty_q;
  assign stat_o.at_end   = at_end;
  assign stat_o.touched  = touched;
  assign stat_o.pend     = pend_q;
  assign stat_o.out_free = out_free;

`ifndef NO_ASSERTIONS
  a_walk_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (col_q >= cmin_q && col_q <= cmax_q && row_q >= rmin_q && row_q <= rmax_q))
    else $error("tile walk left the bounding box");
  a_flush_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_flush |=> (out_valid_q && out_last_q && !pend_q))
    else $error("flush did not deliver a last word");
  a_no_leftover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cap |-> !pend_q)
    else $error("pending tile left over at new triangle");
`endif

endmodule

### hdl/triangle_tile_binner_top.sv
// Triangle tile binner: screen-space triangle in, one word per touched tile out.
// Usage: triangles arrive on in_chan (valid/ready); each is accepted only when the block
// is idle. A triangle of positive orientation is dropped. Otherwise its bounding box,
// rounded to tiles and clamped to the screen, is walked in row-major order and every
// tile not wholly outside an edge yields one word on out_chan with full_cover set
// only for fully inside, full-size tiles; the final word carries last_tile.
// Sequence: five setup steps (capture, deltas, products, cull and bounds, start value),
// then the box is walked one tile per cycle unless a stalled output holds the walk,
// then a flush step sends the last word. A dropped or empty triangle gives no word.
// The first word is sent once the walk meets the second touched tile, or at the flush.
// A stalled receiver holds the output register; the walk halts on the next touched tile
// until a slot frees. Registers are written on cfg_chan (always ready); the user must
// write them only while idle, which the block itself does not enforce.
// Reset: registers return to 8 x 8 tiles and a 512 x 512 screen, outputs go invalid.
// Depends on ttb_pkg, ttb_intf, ttb_ctrl and ttb_dpath.
module triangle_tile_binner_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttb_in_if.sink     in_chan,
  ttb_out_if.source  out_chan,
  ttb_cfg_if.sink    cfg_chan
);

  ttb_pkg::ttb_cmd_t  cmd;
  ttb_pkg::ttb_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  ttb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ttb_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .vert1_x_i    (in_chan.vert1_x),
    .vert1_y_i    (in_chan.vert1_y),
    .vert2_x_i    (in_chan.vert2_x),
    .vert2_y_i    (in_chan.vert2_y),
    .vert3_x_i    (in_chan.vert3_x),
    .vert3_y_i    (in_chan.vert3_y),
    .face_i       (in_chan.face_number),
    .cfg_we_i     (cfg_chan.valid),
    .cfg_idx_i    (cfg_chan.index),
    .cfg_dat_i    (cfg_chan.data),
    .out_ready_i  (out_chan.ready),
    .out_valid_o  (out_chan.valid),
    .tile_col_o   (out_chan.tile_col),
    .tile_row_o   (out_chan.tile_row),
    .face_out_o   (out_chan.face_out),
    .full_cover_o (out_chan.full_cover),
    .last_tile_o  (out_chan.last_tile)
  );

endmodule
